// File: rtl/multilevel_feedback_queue_scheduler_assert.svh
// Assertion macros for the feedback queue scheduler checker.
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH

// Clocked check, disabled during reset.
`define MFQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mfq assertion failed");

// Clocked check that also holds during reset.
`define MFQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("mfq assertion failed");

`endif

// File: rtl/mfq_pkg.sv
// Shared types and constants of the feedback queue scheduler.
`default_nettype none
package mfq_pkg;

  typedef struct packed {
    logic        mode;
    logic [3:0]  arrival_id;
    logic [15:0] arrival_burst;
  } in_t;

  typedef struct packed {
    logic        ran_valid;
    logic [3:0]  ran_id;
    logic [1:0]  ran_level;
    logic [7:0]  quantum_left;
    logic        finished;
    logic        demoted;
    logic [31:0] time_now;
  } out_t;

  // Classified command from the front end to the back end.
  typedef struct packed {
    logic        valid;
    logic        is_tick;
    logic [3:0]  arrival_id;
    logic [15:0] arrival_burst;
  } cmd_t;

  localparam logic MODE_TICK = 1'b1;

  localparam logic [7:0] FIRST_Q_RST  = 8'd4;
  localparam logic [7:0] SECOND_Q_RST = 8'd8;

  localparam int LEVELS = 3;
  localparam logic [1:0] LVL0 = 2'd0;
  localparam logic [1:0] LVL1 = 2'd1;
  localparam logic [1:0] LVL2 = 2'd2;

  localparam logic REG_FIRST_Q  = 1'b0;
  localparam logic REG_SECOND_Q = 1'b1;

endpackage
`default_nettype wire

// File: rtl/mfq_front.sv
// Front end: two-entry input queue that accepts and classifies items.
`default_nettype none
module mfq_front
  import mfq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output cmd_t      cmd,
  input  wire logic cmd_pop
);

  in_t        buf_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  in_t        head;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign head     = buf_r[rd_ptr_r];

  always_comb begin
    cmd.valid         = (cnt_r != 2'd0);
    cmd.is_tick       = (head.mode == MODE_TICK);
    cmd.arrival_id    = head.arrival_id;
    cmd.arrival_burst = head.arrival_burst;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (cmd_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_ptr_r] <= in_data;
  end

endmodule
`default_nettype wire

// File: rtl/mfq_back.sv
// Back end: queue memories, per-task counters and the tick sequencer.
`default_nettype none
module mfq_back
  import mfq_pkg::*;
#(
  parameter int NUM_TASKS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cmd_t       cmd,
  output logic            cmd_pop,
  input  wire logic [7:0] first_q,
  input  wire logic [7:0] second_q,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_t            out_data
);

  localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CW = $clog2(NUM_TASKS + 1);
  localparam int SW = CW + 1;
  localparam int AW = $clog2(3 * NUM_TASKS);

  typedef enum logic [1:0] {S_IDLE, S_QRD, S_EXE} state_t;

  logic [IW-1:0] qmem      [3 * NUM_TASKS];
  logic [15:0]   work_mem  [NUM_TASKS];
  logic [7:0]    quant_mem [NUM_TASKS];

  state_t             state_r;
  logic [NUM_TASKS-1:0] active_r;
  logic [IW-1:0]      head_r  [LEVELS];
  logic [CW-1:0]      count_r [LEVELS];
  logic [31:0]        tick_r;
  logic [1:0]         lvl_r;
  logic [IW-1:0]      id_r;
  logic [IW-1:0]      qrd_r;
  logic [15:0]        work_rd_r;
  logic [7:0]         quant_rd_r;
  logic               out_valid_r;
  out_t               out_r;

  logic          any_ne;
  logic [1:0]    sel_lvl;
  logic          out_free;
  logic [7:0]    id8;
  logic [IW-1:0] arr_idx;
  logic          id_ok;
  logic          enq_write;
  logic          go_tick;
  logic          idle_tick;
  logic          exe_fire;
  logic [AW-1:0] q_raddr;
  logic [1:0]    q_wlvl;
  logic [AW-1:0] q_waddr;
  logic          q_we;
  logic [IW-1:0] q_wd;
  logic [15:0]   work_new;
  logic [7:0]    q_dec;
  logic          upper;
  logic          fin;
  logic          dem;

  function automatic logic [AW-1:0] slot_addr(input logic [1:0] lvl,
                                               input logic [IW-1:0] head,
                                               input logic [CW-1:0] cnt);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(cnt);
    if (s >= SW'(NUM_TASKS)) s = s - SW'(NUM_TASKS);
    return AW'(lvl) * AW'(NUM_TASKS) + AW'(s);
  endfunction

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    any_ne = 1'b1;
    priority if (count_r[0] != '0) sel_lvl = LVL0;
    else if (count_r[1] != '0)     sel_lvl = LVL1;
    else if (count_r[2] != '0)     sel_lvl = LVL2;
    else begin
      sel_lvl = LVL0;
      any_ne  = 1'b0;
    end
  end

  assign id8     = {4'b0, cmd.arrival_id};
  assign arr_idx = id8[IW-1:0];
  assign id_ok   = ({1'b0, id8} < 9'(NUM_TASKS));

  assign enq_write = (state_r == S_IDLE) && cmd.valid && !cmd.is_tick && id_ok &&
                     !active_r[arr_idx];
  assign go_tick   = (state_r == S_IDLE) && cmd.valid && cmd.is_tick && any_ne;
  assign idle_tick = (state_r == S_IDLE) && cmd.valid && cmd.is_tick && !any_ne &&
                     out_free;
  assign cmd_pop   = ((state_r == S_IDLE) && cmd.valid && !cmd.is_tick) ||
                     go_tick || idle_tick;
  assign exe_fire  = (state_r == S_EXE) && out_free;

  // Served task update
  assign work_new = (work_rd_r == 16'd0) ? 16'd0 : work_rd_r - 16'd1;
  assign q_dec    = (quant_rd_r == 8'd0) ? 8'd0 : quant_rd_r - 8'd1;
  assign upper    = (lvl_r != LVL2);
  assign fin      = (work_new == 16'd0);
  assign dem      = !fin && upper && (q_dec == 8'd0);

  assign q_raddr = slot_addr(sel_lvl, head_r[sel_lvl], '0);
  assign q_wlvl  = (state_r == S_EXE) ? ((lvl_r == LVL0) ? LVL1 : LVL2) : LVL0;
  assign q_waddr = slot_addr(q_wlvl, head_r[q_wlvl], count_r[q_wlvl]);
  assign q_we    = enq_write || (exe_fire && dem);
  assign q_wd    = (state_r == S_EXE) ? id_r : arr_idx;

  // Memories
  always_ff @(posedge clk) begin
    if (q_we) qmem[q_waddr] <= q_wd;
    if (state_r == S_IDLE) qrd_r <= qmem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (enq_write) begin
      work_mem[arr_idx]  <= cmd.arrival_burst;
      quant_mem[arr_idx] <= first_q;
    end else if (exe_fire) begin
      work_mem[id_r] <= work_new;
      if (upper) quant_mem[id_r] <= dem ? second_q : q_dec;
    end
    if (state_r == S_QRD) begin
      work_rd_r  <= work_mem[qrd_r];
      quant_rd_r <= quant_mem[qrd_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      tick_r      <= 32'd0;
      out_valid_r <= 1'b0;
      lvl_r       <= LVL0;
      for (int l = 0; l < LEVELS; l++) begin
        head_r[l]  <= '0;
        count_r[l] <= '0;
      end
    end else begin
      if (out_valid_r && out_ready && !idle_tick && !exe_fire) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (enq_write) begin
            active_r[arr_idx] <= 1'b1;
            count_r[0]        <= count_r[0] + CW'(1);
          end
          if (go_tick) begin
            lvl_r   <= sel_lvl;
            state_r <= S_QRD;
          end
          if (idle_tick) begin
            tick_r      <= tick_r + 32'd1;
            out_valid_r <= 1'b1;
            // nothing ran: all fields zero except the tick count
            out_r       <= {1'b0, 4'd0, 2'd0, 8'd0, 1'b0, 1'b0, tick_r + 32'd1};
          end
        end
        S_QRD: begin
          id_r    <= qrd_r;
          state_r <= S_EXE;
        end
        S_EXE: begin
          if (exe_fire) begin
            if (fin || dem) begin
              head_r[lvl_r]  <= (head_r[lvl_r] == IW'(NUM_TASKS - 1)) ? '0 :
                                head_r[lvl_r] + IW'(1);
              count_r[lvl_r] <= count_r[lvl_r] - CW'(1);
            end
            if (dem) count_r[q_wlvl] <= count_r[q_wlvl] + CW'(1);
            if (fin) active_r[id_r] <= 1'b0;
            tick_r             <= tick_r + 32'd1;
            out_valid_r        <= 1'b1;
            out_r.ran_valid    <= 1'b1;
            out_r.ran_id       <= 4'(id_r);
            out_r.ran_level    <= lvl_r;
            out_r.quantum_left <= upper ? q_dec : 8'd0;
            out_r.finished     <= fin;
            out_r.demoted      <= dem;
            out_r.time_now     <= tick_r + 32'd1;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/multilevel_feedback_queue_scheduler.sv
// Top level of the three-level feedback queue scheduler.
// Usage:
//   Input channel (in_valid/in_ready/in_data): mode 0 enqueues task arrival_id
//   with arrival_burst ticks of work at level 0; mode 1 advances one tick.
//   Result channel (out_valid/out_ready/out_data): one result per tick item,
//   telling which task ran, from which level, its quantum left, whether it
//   finished or was demoted, and the tick count.
//   APB port (psel..pready): 0x0 first quantum, 0x4 second quantum; write
//   only while no item is in flight. pready is tied high.
// Sequencing:
//   A two-entry input queue feeds the sequencer. An enqueue is handled in the
//   sequencer's idle state; a tick that serves a task passes through level
//   pick and queue memory read, then task counter read, then update and
//   result, and its result is registered in the last of these. A tick on
//   empty queues is handled in the idle state. The per-task memory read
//   follows the queue memory read, so a served tick takes separate steps.
// Reset clears all queues, task flags and the tick count, and sets the quanta to 4 and 8.
// A stalled receiver holds the result register; the sequencer then waits before
// writing a new result, and the input queue keeps taking items until it holds two.
`default_nettype none
module multilevel_feedback_queue_scheduler
  import mfq_pkg::*;
#(
  parameter int NUM_TASKS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0] first_q_r;
  logic [7:0] second_q_r;
  logic       cfg_wr;
  cmd_t       cmd;
  logic       cmd_pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_SECOND_Q) ? {24'd0, second_q_r} : {24'd0, first_q_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_q_r  <= FIRST_Q_RST;
      second_q_r <= SECOND_Q_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FIRST_Q) first_q_r <= pwdata[7:0];
      else second_q_r <= pwdata[7:0];
    end
  end

  mfq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  mfq_back #(.NUM_TASKS(NUM_TASKS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .first_q   (first_q_r),
    .second_q  (second_q_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: rtl/mfq_checker.sv
// Port-level checker for the feedback queue scheduler, bound to the top level.
`default_nettype none
`include "multilevel_feedback_queue_scheduler_assert.svh"
module mfq_checker
  import mfq_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data,
  input wire logic pready
);

  logic idle_fields_zero;

  assign idle_fields_zero = (out_data.ran_id == 4'd0) && (out_data.ran_level == LVL0) &&
                            (out_data.quantum_left == 8'd0) && !out_data.finished &&
                            !out_data.demoted;

  `MFQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `MFQ_ASSERT(a_idle_zero, out_valid && !out_data.ran_valid |-> idle_fields_zero)
  `MFQ_ASSERT(a_fin_excl, out_valid && out_data.finished |-> out_data.ran_valid && !out_data.demoted)
  `MFQ_ASSERT(a_lvl2, out_valid && out_data.ran_level == LVL2 |-> out_data.quantum_left == 8'd0)
  `MFQ_ASSERT_ALWAYS(a_pready, pready)

endmodule

bind multilevel_feedback_queue_scheduler mfq_checker u_mfq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .pready    (pready)
);
`default_nettype wire
